[src/hsc_pkg.sv]
// hsc_pkg: widths, fixed-point constants and codes for the holt smoother
// with spike clamp; used by the channel interfaces and the top level
package hsc_pkg;

  localparam int COORD_W    = 18;
  localparam int FRAC_BITS  = 16;
  localparam int TREND_W    = COORD_W + 2;
  localparam int GAIN_W     = 17;
  localparam int HIST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SUM_W      = COORD_W + 3;
  localparam int MUL_W      = 23;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV5_SHIFT = 24;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TREND_W-1:0] trend_t;
  typedef logic [GAIN_W-1:0]         gain_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTLEN = 2'd2;

  // operation codes
  localparam logic OP_SMOOTH = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam gain_t GAIN_ONE      = 17'd65536;
  localparam gain_t ALPHA_RESET   = 17'd16384;
  localparam gain_t BETA_RESET    = 17'd9830;
  localparam logic [HIST_W-1:0] HISTLEN_RESET   = 8'd5;
  localparam logic [HIST_W-1:0] CLAMP_MIN_COUNT = 8'd3;

  // floor(0.0225 * 2^32)
  localparam logic signed [PROD_W-1:0] SPIKE_LIMIT_SQ = 46'sd96636764;

  // floor(n/5) = (n * ceil(2^24/5)) >> 24 for 0 <= n < 2^21
  localparam logic signed [MUL_W-1:0] DIV5_MUL  = 23'sd3355444;
  localparam logic [SUM_W-1:0]        DIV5_BIAS = 21'd1310720;
  localparam logic [TREND_W-1:0]      DIV5_OFS  = 20'd262144;

  localparam logic signed [PROD_W-1:0] COORD_MAX_P = 46'sd131071;
  localparam logic signed [PROD_W-1:0] COORD_MIN_P = -46'sd131072;
  localparam logic signed [PROD_W-1:0] TREND_MAX_P = 46'sd524287;
  localparam logic signed [PROD_W-1:0] TREND_MIN_P = -46'sd524288;

  localparam coord_t COORD_MAX = 18'sh1FFFF;
  localparam coord_t COORD_MIN = 18'sh20000;
  localparam trend_t TREND_MAX = 20'sh7FFFF;
  localparam trend_t TREND_MIN = 20'sh80000;

endpackage

[src/hsc_in_if.sv]
// hsc_in_if: request channel of raw points into the smoother
// depends on hsc_pkg for the coordinate type
interface hsc_in_if;
  logic           valid;
  logic           ready;
  logic           operation;
  hsc_pkg::coord_t x_in;
  hsc_pkg::coord_t y_in;

  modport source (output valid, output operation, output x_in, output y_in, input ready);
  modport sink   (input valid, input operation, input x_in, input y_in, output ready);
endinterface

[src/hsc_out_if.sv]
// hsc_out_if: channel of smoothed points out of the smoother
// depends on hsc_pkg for the coordinate type
interface hsc_out_if;
  logic           valid;
  logic           ready;
  hsc_pkg::coord_t x_out;
  hsc_pkg::coord_t y_out;

  modport source (output valid, output x_out, output y_out, input ready);
  modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

[src/holt_smoother_2d_spike_clamp.sv]
// holt_smoother_2d_spike_clamp: 2d holt smoother with spike clamp, one shared
// 23x23 multiplier under a small sequencer; uses hsc_pkg, hsc_in_if, hsc_out_if
// sequence: a clear resets the state while idle; a first sample loads the level and goes
//   straight to the output state; a primed sample runs one multiply a cycle through
//   2 squares, 2 clamp divides when clamped and 4 products per axis, then loads the result
// flow: requests are taken only in idle; stalls in the output state while a result is unread
// reset: synchronous active-low rst_n clears state and loads register defaults
module holt_smoother_2d_spike_clamp (
  input  logic                             clk,
  input  logic                             rst_n,
  hsc_in_if.sink                           in_chan,
  hsc_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [hsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_CLX  = 4'd3;
  localparam logic [3:0] S_CLY  = 4'd4;
  localparam logic [3:0] S_LV1  = 4'd5;
  localparam logic [3:0] S_LV2  = 4'd6;
  localparam logic [3:0] S_TR1  = 4'd7;
  localparam logic [3:0] S_TR2  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                         state_r, state_nxt;
  logic                               axis_r, axis_nxt;
  logic                               primed_r, primed_nxt;
  hsc_pkg::gain_t                     alpha_r, beta_r;
  logic [hsc_pkg::HIST_W-1:0]         histlen_r;
  logic [hsc_pkg::HIST_W-1:0]         count_r, count_nxt;
  hsc_pkg::coord_t                    level_x_r, level_x_nxt, level_y_r, level_y_nxt;
  hsc_pkg::trend_t                    trend_x_r, trend_x_nxt, trend_y_r, trend_y_nxt;
  hsc_pkg::coord_t                    x_r, x_nxt, y_r, y_nxt;
  logic signed [hsc_pkg::DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [hsc_pkg::PROD_W-1:0]  acc_r, acc_nxt;
  logic                               out_valid_r;
  hsc_pkg::coord_t                    out_x_r, out_y_r;

  hsc_pkg::coord_t                    sample_sel, level_sel;
  hsc_pkg::trend_t                    trend_sel;
  logic signed [hsc_pkg::DIFF_W-1:0]  dev_w, new_diff;
  logic [hsc_pkg::SUM_W-1:0]          div_num;
  logic signed [hsc_pkg::SUM_W-1:0]   lt_sum;
  hsc_pkg::gain_t                     alpha_c, beta_c;
  logic signed [hsc_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [hsc_pkg::PROD_W-1:0]  prod, acc_sum, sh_w;
  hsc_pkg::coord_t                    lvl_sat, clamped;
  hsc_pkg::trend_t                    trd_sat, clamp_sum;
  logic                               in_acc, out_free;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && (state_r == S_IDLE);
  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.x_out = out_x_r;
  assign out_chan.y_out = out_y_r;

  // per-axis operand selection
  assign sample_sel = axis_r ? y_r : x_r;
  assign level_sel  = axis_r ? level_y_r : level_x_r;
  assign trend_sel  = axis_r ? trend_y_r : trend_x_r;
  assign dev_w      = {sample_sel[hsc_pkg::COORD_W-1], sample_sel}
                    - {level_sel[hsc_pkg::COORD_W-1], level_sel};
  assign div_num    = {{2{dev_w[hsc_pkg::DIFF_W-1]}}, dev_w} + hsc_pkg::DIV5_BIAS;
  assign lt_sum     = {{3{level_sel[hsc_pkg::COORD_W-1]}}, level_sel}
                    + {trend_sel[hsc_pkg::TREND_W-1], trend_sel};
  assign alpha_c    = hsc_pkg::GAIN_ONE - alpha_r;
  assign beta_c     = hsc_pkg::GAIN_ONE - beta_r;

  always_comb begin
    case (state_r)
      S_SQX, S_SQY: begin
        mul_a = {{4{dev_w[hsc_pkg::DIFF_W-1]}}, dev_w};
        mul_b = {{4{dev_w[hsc_pkg::DIFF_W-1]}}, dev_w};
      end
      S_CLX, S_CLY: begin
        mul_a = {2'b00, div_num};
        mul_b = hsc_pkg::DIV5_MUL;
      end
      S_LV1: begin
        mul_a = {6'd0, alpha_r};
        mul_b = {{5{sample_sel[hsc_pkg::COORD_W-1]}}, sample_sel};
      end
      S_LV2: begin
        mul_a = {6'd0, alpha_c};
        mul_b = {{2{lt_sum[hsc_pkg::SUM_W-1]}}, lt_sum};
      end
      S_TR1: begin
        mul_a = {6'd0, beta_r};
        mul_b = {{4{diff_r[hsc_pkg::DIFF_W-1]}}, diff_r};
      end
      S_TR2: begin
        mul_a = {6'd0, beta_c};
        mul_b = {{3{trend_sel[hsc_pkg::TREND_W-1]}}, trend_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_r + prod;
  assign sh_w    = acc_sum >>> hsc_pkg::FRAC_BITS;

  always_comb begin
    if (sh_w > hsc_pkg::COORD_MAX_P) begin
      lvl_sat = hsc_pkg::COORD_MAX;
    end else if (sh_w < hsc_pkg::COORD_MIN_P) begin
      lvl_sat = hsc_pkg::COORD_MIN;
    end else begin
      lvl_sat = sh_w[hsc_pkg::COORD_W-1:0];
    end
    if (sh_w > hsc_pkg::TREND_MAX_P) begin
      trd_sat = hsc_pkg::TREND_MAX;
    end else if (sh_w < hsc_pkg::TREND_MIN_P) begin
      trd_sat = hsc_pkg::TREND_MIN;
    end else begin
      trd_sat = sh_w[hsc_pkg::TREND_W-1:0];
    end
  end

  assign new_diff  = {lvl_sat[hsc_pkg::COORD_W-1], lvl_sat}
                   - {level_sel[hsc_pkg::COORD_W-1], level_sel};
  // level + floor(dev/5), the bias undone after the reciprocal multiply
  assign clamp_sum = {{2{level_sel[hsc_pkg::COORD_W-1]}}, level_sel}
                   + prod[hsc_pkg::DIV5_SHIFT+hsc_pkg::TREND_W-1:hsc_pkg::DIV5_SHIFT]
                   - hsc_pkg::DIV5_OFS;
  assign clamped   = clamp_sum[hsc_pkg::COORD_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    primed_nxt  = primed_r;
    count_nxt   = count_r;
    level_x_nxt = level_x_r;
    level_y_nxt = level_y_r;
    trend_x_nxt = trend_x_r;
    trend_y_nxt = trend_y_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    diff_nxt    = diff_r;
    acc_nxt     = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.operation == hsc_pkg::OP_CLEAR) begin
            primed_nxt  = 1'b0;
            count_nxt   = '0;
            level_x_nxt = '0;
            level_y_nxt = '0;
            trend_x_nxt = '0;
            trend_y_nxt = '0;
          end else if (!primed_r) begin
            primed_nxt  = 1'b1;
            count_nxt   = 8'd1;
            level_x_nxt = in_chan.x_in;
            level_y_nxt = in_chan.y_in;
            trend_x_nxt = '0;
            trend_y_nxt = '0;
            state_nxt   = S_OUT;
          end else begin
            x_nxt     = in_chan.x_in;
            y_nxt     = in_chan.y_in;
            axis_nxt  = 1'b0;
            state_nxt = S_SQX;
          end
        end
      end
      S_SQX: begin
        acc_nxt   = prod;
        axis_nxt  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        axis_nxt  = 1'b0;
        state_nxt = ((acc_sum > hsc_pkg::SPIKE_LIMIT_SQ)
                    && (count_r >= hsc_pkg::CLAMP_MIN_COUNT)) ? S_CLX : S_LV1;
      end
      S_CLX: begin
        x_nxt     = clamped;
        axis_nxt  = 1'b1;
        state_nxt = S_CLY;
      end
      S_CLY: begin
        y_nxt     = clamped;
        axis_nxt  = 1'b0;
        state_nxt = S_LV1;
      end
      S_LV1: begin
        acc_nxt   = prod;
        state_nxt = S_LV2;
      end
      S_LV2: begin
        diff_nxt = new_diff;
        if (axis_r) begin
          level_y_nxt = lvl_sat;
        end else begin
          level_x_nxt = lvl_sat;
        end
        state_nxt = S_TR1;
      end
      S_TR1: begin
        acc_nxt   = prod;
        state_nxt = S_TR2;
      end
      S_TR2: begin
        if (axis_r) begin
          trend_y_nxt = trd_sat;
          if (count_r < histlen_r) begin
            count_nxt = count_r + 8'd1;
          end
          state_nxt = S_OUT;
        end else begin
          trend_x_nxt = trd_sat;
          axis_nxt    = 1'b1;
          state_nxt   = S_LV1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      primed_r    <= 1'b0;
      count_r     <= '0;
      level_x_r   <= '0;
      level_y_r   <= '0;
      trend_x_r   <= '0;
      trend_y_r   <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= hsc_pkg::ALPHA_RESET;
      beta_r      <= hsc_pkg::BETA_RESET;
      histlen_r   <= hsc_pkg::HISTLEN_RESET;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      primed_r  <= primed_nxt;
      count_r   <= count_nxt;
      level_x_r <= level_x_nxt;
      level_y_r <= level_y_nxt;
      trend_x_r <= trend_x_nxt;
      trend_y_r <= trend_y_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // invalid values leave the register as is
      if (cfg_we) begin
        case (cfg_index)
          hsc_pkg::CFG_ALPHA: begin
            if (cfg_data != '0 && cfg_data <= hsc_pkg::GAIN_ONE) begin
              alpha_r <= cfg_data;
            end
          end
          hsc_pkg::CFG_BETA: begin
            if (cfg_data <= hsc_pkg::GAIN_ONE) begin
              beta_r <= cfg_data;
            end
          end
          hsc_pkg::CFG_HISTLEN: begin
            if (cfg_data[hsc_pkg::HIST_W-1:0] != '0) begin
              histlen_r <= cfg_data[hsc_pkg::HIST_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    diff_r <= diff_nxt;
    acc_r  <= acc_nxt;
    if (state_r == S_OUT && out_free) begin
      out_x_r <= level_x_r;
      out_y_r <= level_y_r;
    end
  end

  a_unprimed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (count_r == '0) && (trend_x_r == '0) && (trend_y_r == '0))
    else $error("unprimed smoother holds history or trend");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.operation == hsc_pkg::OP_CLEAR)
    |=> !primed_r && (state_r == S_IDLE) && (level_x_r == '0) && (level_y_r == '0))
    else $error("clear request did not reset the state");

  a_start_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && !in_chan.valid |=> (state_r == S_IDLE))
    else $error("sequencer left idle without a request");

  a_result_is_level: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(state_r == S_OUT && out_free)
    |-> out_valid_r && (out_x_r == level_x_r) && (out_y_r == level_y_r))
    else $error("result does not match the stored level");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TR2) && axis_r && (count_r < histlen_r) |=> (count_r == $past(count_r) + 8'd1))
    else $error("history count did not advance");

endmodule

[tb/holt_point_checker.sv]
`timescale 1ns / 100ps
// holt_point_checker: watches the request, result and register ports of the
// holt smoother, predicts each smoothed point and compares; uses hsc_pkg
module holt_point_checker import hsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_operation,
  input  coord_t                in_x,
  input  coord_t                in_y,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  coord_t                out_x,
  input  coord_t                out_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due,
  output int                    n_checked,
  output int                    n_clamped
);

  localparam int     GAIN_SHIFT    = GAIN_W - 1;
  localparam longint GAIN_UNIT     = longint'(GAIN_ONE);
  localparam longint JUMP_LIMIT_SQ = (longint'(9) << (2 * FRAC_BITS)) / 400;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  point_t pending_points[$];

  // predictor copy of the registers and the tracking state
  gain_t             alpha_q;
  gain_t             beta_q;
  logic [HIST_W-1:0] hist_len;
  logic              primed_q;
  coord_t            lvl_x, lvl_y;
  trend_t            trd_x, trd_y;
  logic [HIST_W-1:0] hist_cnt;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint fifth_floor(longint v);
    longint q;
    q = v / 5;
    if (v < 0 && q * 5 != v) q = q - 1;
    return q;
  endfunction

  function automatic void blend_axis(input longint s, inout longint lvl, inout longint trd);
    longint a, b, nl;
    a  = longint'(alpha_q);
    b  = longint'(beta_q);
    nl = clip((a * s + (GAIN_UNIT - a) * (lvl + trd)) >>> GAIN_SHIFT,
              longint'(COORD_MIN), longint'(COORD_MAX));
    trd = clip((b * (nl - lvl) + (GAIN_UNIT - b) * trd) >>> GAIN_SHIFT,
               longint'(TREND_MIN), longint'(TREND_MAX));
    lvl = nl;
  endfunction

  function automatic void forget_track();
    primed_q = 1'b0;
    lvl_x    = '0;
    lvl_y    = '0;
    trd_x    = '0;
    trd_y    = '0;
    hist_cnt = '0;
  endfunction

  function automatic void track_point(input coord_t xs, input coord_t ys, output bit clamped);
    longint sx, sy, dx, dy, lx, ly, tx, ty;
    sx      = xs;
    sy      = ys;
    clamped = 1'b0;
    if (!primed_q) begin
      lvl_x    = xs;
      lvl_y    = ys;
      trd_x    = '0;
      trd_y    = '0;
      primed_q = 1'b1;
      hist_cnt = 8'd1;
    end else begin
      lx = lvl_x;
      ly = lvl_y;
      tx = trd_x;
      ty = trd_y;
      dx = sx - lx;
      dy = sy - ly;
      // jump clamp: move to a fifth of the way once enough history exists
      if (dx * dx + dy * dy > JUMP_LIMIT_SQ && hist_cnt >= CLAMP_MIN_COUNT) begin
        sx      = lx + fifth_floor(dx);
        sy      = ly + fifth_floor(dy);
        clamped = 1'b1;
      end
      blend_axis(sx, lx, tx);
      blend_axis(sy, ly, ty);
      lvl_x = coord_t'(lx);
      lvl_y = coord_t'(ly);
      trd_x = trend_t'(tx);
      trd_y = trend_t'(ty);
      if (hist_cnt < hist_len) hist_cnt = hist_cnt + 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    point_t want;
    bit     clamped;
    if (!rst_n) begin
      alpha_q  = ALPHA_RESET;
      beta_q   = BETA_RESET;
      hist_len = HISTLEN_RESET;
      forget_track();
      pending_points.delete();
      fail_count = 0;
      n_checked  = 0;
      n_clamped  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA: if (cfg_data != '0 && cfg_data <= GAIN_ONE) alpha_q = cfg_data;
          CFG_BETA: if (cfg_data <= GAIN_ONE) beta_q = cfg_data;
          CFG_HISTLEN: if (cfg_data[HIST_W-1:0] != '0) hist_len = cfg_data[HIST_W-1:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          $error("result with no request waiting: x_out %0d, y_out %0d", out_x, out_y);
          fail_count++;
        end else begin
          want = pending_points[0];
          pending_points.delete(0);
          n_checked++;
          if (out_x !== want.x) begin
            $error("x_out mismatch: expected %0d, actual %0d", want.x, out_x);
            fail_count++;
          end
          if (out_y !== want.y) begin
            $error("y_out mismatch: expected %0d, actual %0d", want.y, out_y);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_CLEAR) begin
          forget_track();
        end else begin
          track_point(in_x, in_y, clamped);
          if (clamped) n_clamped++;
          want.x = lvl_x;
          want.y = lvl_y;
          pending_points.insert(pending_points.size(), want);
        end
      end
    end
    results_due <= pending_points.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for holt_smoother_2d_spike_clamp; drives the
// request and register ports, stalls the result side; needs holt_point_checker
module tb_top;
  import hsc_pkg::*;

  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 5000;
  localparam int WALK_SPAN     = 3000;
  localparam int SPIKE_SPAN    = 60000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int     fail_count, results_due, n_checked, n_clamped;
  int     n_sent, n_clears, n_writes;
  int     burst_left;
  int     idle_cycles;
  coord_t track_x, track_y;

  hsc_in_if  in_ch();
  hsc_out_if out_ch();

  holt_smoother_2d_spike_clamp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  holt_point_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_operation(in_ch.operation),
    .in_x        (in_ch.x_in),
    .in_y        (in_ch.y_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_x       (out_ch.x_out),
    .out_y       (out_ch.y_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due),
    .n_checked   (n_checked),
    .n_clamped   (n_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure, switching between stall patterns
  initial begin : receiver
    rx_mode_t rx_mode;
    int       rx_span, rx_tick, rx_period, rx_hold;
    rx_mode   = RX_OPEN;
    rx_span   = 0;
    rx_tick   = 0;
    rx_period = 2;
    rx_hold   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_span == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        rx_span   = $urandom_range(50, 300);
        rx_period = $urandom_range(2, 5);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN: out_ch.ready <= 1'b1;
        RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ch.ready <= (rx_tick % rx_period == 0);
        default: begin
          if (rx_hold == 0) rx_hold = $urandom_range(1, 30);
          rx_hold--;
          out_ch.ready <= (rx_hold < 2);
        end
      endcase
    end
  end

  // ends the run when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic op, input coord_t x, input coord_t y);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.x_in      <= x;
    in_ch.y_in      <= y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    n_sent++;
    if (op == OP_CLEAR) n_clears++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    n_writes++;
  endtask

  // stop sending, let every result drain and the block fall idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t nudge(coord_t p, int span);
    int v;
    v = int'(p) + int'($urandom_range(0, 2 * span)) - span;
    if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
    if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // mostly a smooth random walk, with spikes, noise, extremes and clears mixed in
  task automatic send_track_step();
    int unsigned roll;
    logic        op;
    coord_t      px, py;
    roll = $urandom_range(0, 99);
    op   = OP_SMOOTH;
    if (roll < 4) begin
      op = OP_CLEAR;
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end else if (roll < 76) begin
      track_x = nudge(track_x, WALK_SPAN);
      track_y = nudge(track_y, WALK_SPAN);
      px      = track_x;
      py      = track_y;
    end else if (roll < 88) begin
      px = nudge(track_x, SPIKE_SPAN);
      py = nudge(track_y, SPIKE_SPAN);
    end else if (roll < 96) begin
      track_x = coord_t'($urandom);
      track_y = coord_t'($urandom);
      px      = track_x;
      py      = track_y;
    end else begin
      px = extreme_coord();
      py = extreme_coord();
    end
    send_req(op, px, py);
  endtask

  task automatic run_phase(input gain_t a, input gain_t b, input logic [HIST_W-1:0] h);
    logic [CFG_IDX_W-1:0] junk_idx;
    settle();
    junk_idx = CFG_IDX_W'($urandom_range(0, 3));
    write_reg(junk_idx, CFG_DATA_W'($urandom));
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_BETA, b);
    write_reg(CFG_HISTLEN, CFG_DATA_W'(h));
    cfg_we <= 1'b0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) settle();
      send_track_step();
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_SMOOTH;
    in_ch.x_in      <= '0;
    in_ch.y_in      <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ALPHA;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    burst_left  = 0;
    n_sent      = 0;
    n_clears    = 0;
    n_writes    = 0;
    track_x     = '0;
    track_y     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: pass-through, unclamped jumps while history is short, then a clamp
    send_req(OP_SMOOTH, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, COORD_MAX, COORD_MIN);
    send_req(OP_SMOOTH, COORD_MIN, COORD_MAX);
    send_req(OP_SMOOTH, COORD_MAX, COORD_MAX);
    send_req(OP_CLEAR, COORD_MAX, COORD_MIN);
    send_req(OP_SMOOTH, COORD_MIN, COORD_MIN);
    send_req(OP_CLEAR, coord_t'(0), coord_t'(0));
    settle();

    // out-of-range and unmapped writes must not stick
    write_reg(CFG_ALPHA, '0);
    write_reg(CFG_ALPHA, GAIN_ONE + 17'd1);
    write_reg(CFG_BETA, '1);
    write_reg(CFG_HISTLEN, 17'h100);
    write_reg(CFG_HISTLEN, '0);
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_ALPHA, GAIN_ONE);
    write_reg(CFG_BETA, GAIN_ONE);
    cfg_we <= 1'b0;
    send_req(OP_SMOOTH, COORD_MIN, COORD_MAX);
    send_req(OP_SMOOTH, COORD_MAX, COORD_MIN);
    settle();

    // tiny level gain with a full-scale trend drives the level into saturation
    write_reg(CFG_ALPHA, 17'd1);
    cfg_we <= 1'b0;
    send_req(OP_SMOOTH, COORD_MAX, COORD_MIN);
    settle();

    // level follows the sample exactly: probe the jump threshold on both sides
    write_reg(CFG_ALPHA, GAIN_ONE);
    write_reg(CFG_BETA, '0);
    write_reg(CFG_HISTLEN, 17'd255);
    cfg_we <= 1'b0;
    send_req(OP_CLEAR, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(9830), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(0), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(9831), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(-7865), coord_t'(0));
    send_req(OP_SMOOTH, coord_t'(6950), coord_t'(6951));
    send_req(OP_SMOOTH, coord_t'(-2), coord_t'(-1));
    settle();

    // history bound lowered below the count: count holds, clamp stays armed
    write_reg(CFG_HISTLEN, 17'd1);
    cfg_we <= 1'b0;
    send_req(OP_SMOOTH, COORD_MAX, COORD_MAX);
    send_req(OP_CLEAR, COORD_MIN, COORD_MAX);
    send_req(OP_SMOOTH, COORD_MAX, COORD_MAX);
    send_req(OP_SMOOTH, COORD_MIN, COORD_MIN);

    run_phase(ALPHA_RESET, BETA_RESET, HISTLEN_RESET);
    run_phase(GAIN_ONE, GAIN_ONE, 8'd255);
    run_phase(17'd1, 17'd0, 8'd1);
    run_phase(17'd1, GAIN_ONE, CLAMP_MIN_COUNT);
    run_phase(GAIN_ONE, 17'd0, 8'd2);
    run_phase(gain_t'($urandom_range(1, 65536)), gain_t'($urandom_range(0, 65536)),
              HIST_W'($urandom_range(1, 255)));
    run_phase(gain_t'($urandom_range(1, 65536)), gain_t'($urandom_range(0, 65536)),
              HIST_W'($urandom_range(1, 255)));
    settle();

    $display("sent %0d requests (%0d clears) across %0d register writes",
             n_sent, n_clears, n_writes);
    $display("compared %0d smoothed points, %0d of them from clamped jumps",
             n_checked, n_clamped);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
